FILE: rtl/core/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared constants, codes and types of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int FRAME_BITS = 12;
  localparam int CF_W       = FRAME_BITS + 1;
  localparam int TOTAL_W    = FRAME_BITS + 1;
  localparam int PROD_W     = 14;
  localparam int CAP_W      = (TOTAL_W > PROD_W) ? TOTAL_W : PROD_W;
  localparam int SW         = FRAME_BITS + 3;
  localparam int DIV_CNT_W  = $clog2(FRAME_BITS);
  localparam int ADDR_W     = 5;

  localparam int IN_TDATA_W  = ((FRAME_BITS + 7) / 8) * 8;
  localparam int OUT_W       = FRAME_BITS + 46;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // output field offsets inside m_tdata
  localparam int O_SHOWN = FRAME_BITS;
  localparam int O_FIN   = FRAME_BITS + 1;
  localparam int O_COL   = FRAME_BITS + 2;
  localparam int O_ROW   = FRAME_BITS + 8;
  localparam int O_SX    = FRAME_BITS + 14;
  localparam int O_SY    = FRAME_BITS + 30;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_SET     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] LOOP_NORMAL = 2'd0;
  localparam logic [1:0] LOOP_PING   = 2'd1;
  localparam logic [1:0] LOOP_ONCE   = 2'd2;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd3;

  localparam logic [2:0] REG_UPF  = 3'd0;
  localparam logic [2:0] REG_FPR  = 3'd1;
  localparam logic [2:0] REG_FPC  = 3'd2;
  localparam logic [2:0] REG_LOOP = 3'd3;
  localparam logic [2:0] REG_FW   = 3'd4;
  localparam logic [2:0] REG_FH   = 3'd5;

  typedef struct packed {
    logic [15:0] upf;
    logic [6:0]  fpr;
    logic [6:0]  fpc;
    logic [1:0]  loop_mode;
    logic [10:0] fw;
    logic [10:0] fh;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic step;
    logic div_init;
    logic div_step;
    logic mul;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

  function automatic logic [6:0] clamp_dim(logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) r = 7'd1;
    else if (v > 7'd64) r = 7'd64;
    return r;
  endfunction

  function automatic logic [10:0] clamp_px(logic [10:0] v);
    return (v > 11'd1024) ? 11'd1024 : v;
  endfunction

endpackage

FILE: rtl/core/sfs_regs.sv
// ----------------------------------------------------------------------------
// sfs_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module sfs_regs
  import sfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.upf       <= 16'd1;
      cfg.fpr       <= 7'd1;
      cfg.fpc       <= 7'd1;
      cfg.loop_mode <= LOOP_NORMAL;
      cfg.fw        <= 11'd1;
      cfg.fh        <= 11'd1;
    end else if (wr) begin
      unique case (idx)
        REG_UPF:  cfg.upf       <= pwdata[15:0];
        REG_FPR:  cfg.fpr       <= pwdata[6:0];
        REG_FPC:  cfg.fpc       <= pwdata[6:0];
        REG_LOOP: cfg.loop_mode <= pwdata[1:0];
        REG_FW:   cfg.fw        <= pwdata[10:0];
        REG_FH:   cfg.fh        <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_UPF:  prdata = {16'd0, cfg.upf};
      REG_FPR:  prdata = {25'd0, cfg.fpr};
      REG_FPC:  prdata = {25'd0, cfg.fpc};
      REG_LOOP: prdata = {30'd0, cfg.loop_mode};
      REG_FW:   prdata = {21'd0, cfg.fw};
      REG_FH:   prdata = {21'd0, cfg.fh};
      default:  prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/core/sfs_ctrl.sv
// ----------------------------------------------------------------------------
// sfs_ctrl
// Command sequencer: steps one command through total, update, divide,
// multiply and output, and owns the stream handshakes.
// ----------------------------------------------------------------------------
module sfs_ctrl
  import sfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE, S_TOTAL, S_STEP, S_DINIT, S_DIV, S_MUL, S_OUT
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = s_tvalid && s_tready;
    cmd.calc     = (state == S_TOTAL);
    cmd.step     = (state == S_STEP);
    cmd.div_init = (state == S_DINIT);
    cmd.div_step = (state == S_DIV);
    cmd.mul      = (state == S_MUL);
    cmd.out_load = (state == S_OUT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE:  if (cmd.load) state <= S_TOTAL;
        S_TOTAL: state <= S_STEP;
        S_STEP:  state <= S_DINIT;
        S_DINIT: state <= S_DIV;
        S_DIV:   if (status.div_last) state <= S_MUL;
        S_MUL:   state <= S_OUT;
        S_OUT:   if (cmd.out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/sfs_datapath.sv
// ----------------------------------------------------------------------------
// sfs_datapath
// Frame state, frame update, restoring column/row divider, pixel offset
// multipliers and the output register.
// ----------------------------------------------------------------------------
module sfs_datapath
  import sfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [1:0]             s_tuser,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // command and frame state
  logic [1:0]                cmd_r;
  logic [FRAME_BITS-1:0]     req_r;
  logic [15:0]               tc;
  logic signed [CF_W-1:0]    cf;
  logic [1:0]                dir;
  logic                      done;

  // per-command working values
  logic [TOTAL_W-1:0]        total_r;
  logic [6:0]                fpr_c;
  logic [15:0]               upf_c;

  // divider and offsets
  logic [FRAME_BITS-1:0]     quo;
  logic [6:0]                rem;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic [FRAME_BITS-1:0]     idx_r;
  logic                      shown_r;
  logic [5:0]                col_r;
  logic [5:0]                row_r;

  // next values
  logic [15:0]               tc_next;
  logic signed [CF_W-1:0]    cf_next;
  logic [1:0]                dir_next;
  logic                      done_next;

  logic [PROD_W-1:0]         prod;
  logic [CAP_W-1:0]          prod_w;
  logic [CAP_W-1:0]          cap;
  logic [6:0]                trial;
  logic                      ge;
  logic                      shown;
  logic [16:0]               px;
  logic [16:0]               py;

  assign status.div_last = (div_cnt == DIV_CNT_W'(FRAME_BITS - 1));

  assign prod   = PROD_W'(clamp_dim(cfg.fpr)) * PROD_W'(clamp_dim(cfg.fpc));
  assign prod_w = CAP_W'(prod);
  assign cap    = CAP_W'(1) << FRAME_BITS;

  assign trial = {rem[5:0], quo[FRAME_BITS-1]};
  assign ge    = (trial >= fpr_c);
  assign shown = !cf[CF_W-1] && (TOTAL_W'(cf[CF_W-2:0]) < total_r);

  assign px = 17'(clamp_px(cfg.fw)) * 17'(col_r);
  assign py = 17'(clamp_px(cfg.fh)) * 17'(row_r);

  always_comb begin
    logic signed [SW-1:0] cfw;
    logic signed [SW-1:0] tot;
    logic signed [SW-1:0] last;
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] reqw;
    logic [15:0]          tc1;
    cfw       = $signed({{(SW-CF_W){cf[CF_W-1]}}, cf});
    tot       = $signed({{(SW-TOTAL_W){1'b0}}, total_r});
    last      = tot - SW'(1);
    reqw      = $signed({{(SW-FRAME_BITS){1'b0}}, req_r});
    tc1       = tc + 16'd1;
    a         = cfw;
    tc_next   = tc;
    cf_next   = cf;
    dir_next  = dir;
    done_next = done;
    unique case (cmd_r)
      CMD_TICK: begin
        tc_next = tc1;
        if (tc1 >= upf_c) begin
          tc_next = tc1 - upf_c;
          unique case (cfg.loop_mode)
            LOOP_PING: begin
              if (dir == DIR_FWD) begin
                a = cfw + SW'(1);
                if (a >= tot) begin
                  a        = a - SW'(2);
                  dir_next = DIR_BACK;
                end
              end else if (dir == DIR_BACK) begin
                a = cfw - SW'(1);
                if (a < 0) begin
                  a        = a + SW'(2);
                  dir_next = DIR_FWD;
                end
              end
            end
            LOOP_NORMAL: begin
              a = cfw + SW'(1);
              if (a >= tot) a = '0;
            end
            LOOP_ONCE: begin
              if (dir != DIR_STOP) begin
                a = cfw + SW'(1);
                if (a >= tot) begin
                  a         = last;
                  dir_next  = DIR_STOP;
                  done_next = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        if (a < 0) a = '0;
        if (a > last) a = last;
        cf_next = a[CF_W-1:0];
      end
      CMD_SET: begin
        a       = (reqw > last) ? last : reqw;
        cf_next = a[CF_W-1:0];
        tc_next = 16'd0;
      end
      CMD_RESTART: begin
        dir_next  = DIR_FWD;
        cf_next   = '1;
        tc_next   = 16'd0;
        done_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tc   <= 16'd0;
      cf   <= '1;
      dir  <= DIR_FWD;
      done <= 1'b0;
    end else if (cmd.step) begin
      tc   <= tc_next;
      cf   <= cf_next;
      dir  <= dir_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= s_tuser;
      req_r <= s_tdata[FRAME_BITS-1:0];
    end
    if (cmd.calc) begin
      fpr_c   <= clamp_dim(cfg.fpr);
      upf_c   <= (cfg.upf == 16'd0) ? 16'd1 : cfg.upf;
      total_r <= TOTAL_W'((prod_w > cap) ? cap : prod_w);
    end
    if (cmd.div_init) begin
      shown_r <= shown;
      idx_r   <= shown ? cf[FRAME_BITS-1:0] : '0;
      quo     <= shown ? cf[FRAME_BITS-1:0] : '0;
      rem     <= 7'd0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= ge ? (trial - fpr_c) : trial;
      quo     <= {quo[FRAME_BITS-2:0], ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.mul) begin
      col_r <= rem[5:0];
      row_r <= quo[5:0];
    end
    if (cmd.out_load) begin
      m_tdata <= OUT_TDATA_W'({py[15:0], px[15:0], row_r, col_r, done, shown_r, idx_r});
    end
  end

endmodule

FILE: rtl/core/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Sprite sheet frame sequencer: tick, set frame and restart commands, each
// answered with the frame index, sheet column/row and source pixel offset.
// Each command steps through the total, update, divider init, divide,
//   multiply and output states; the next command is taken only when idle.
//   A one bit per cycle restoring divider splits the frame into column/row.
// A finished result waits in the output register while the next command
//   is taken. Reset (rst, synchronous): registers at their reset values,
//   frame index -1 (not shown), count zero, direction forward.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer
  import sfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // frame_value
  input  logic [1:0]             s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // frame_index, frame_shown, finished, sheet_column, sheet_row,
  // source_x, source_y
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  sfs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  sfs_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .status  (status),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata)
  );

endmodule

FILE: rtl/core/sfs_checker.sv
// ----------------------------------------------------------------------------
// sfs_checker
// Port-level checks of the sprite frame sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sfs_checker
  import sfs_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic [1:0]             s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one command in flight
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command taken while busy");

  // hidden frame reports zero index, column, row and offsets
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[O_SHOWN] |->
      m_tdata[FRAME_BITS-1:0] == '0 && m_tdata[O_SY+15:O_COL] == '0)
    else $error("hidden frame with nonzero fields");

  // idle after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);
